/* rtl/lebw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sheared periodic boundary block.
// Used by lebw_ctrl, lebw_dp and lees_edwards_boundary_wrap; depends on nothing.
package lebw_pkg;

	localparam int ImageBitsDefault = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgW = 32;

	// Shear shift is Q32.16 held in 48 bits.
	localparam int ShiftW = 48;

	// The y fold divides a 50-bit magnitude, two quotient bits per cycle.
	localparam int DivW = 50;
	localparam int DivSteps = DivW / 2;
	localparam int DivCntW = $clog2(DivSteps);

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_MODE = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SVEL = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SSET = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_DT = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LOX = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_PX = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_LOY = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_PY = 3'd7;

	localparam logic [30:0] PeriodReset = 31'd65536;

	localparam logic signed [49:0] Sat32Max = 50'sd2147483647;
	localparam logic signed [49:0] Sat32Min = -50'sd2147483648;

	typedef struct packed {
		logic load_in;
		logic tick_mul;
		logic tick_add;
		logic tick_set;
		logic cross_chk;
		logic prep;
		logic div_step;
		logic fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic fold;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > Sat32Max) begin
			return Sat32Max[31:0];
		end else if (v < Sat32Min) begin
			return Sat32Min[31:0];
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

/* rtl/lebw_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the boundary block: input handshake, step commands, output valid.
// Depends on lebw_pkg for the command and status structs.
module lebw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  lebw_pkg::sts_t   sts,
	output lebw_pkg::cmd_t   cmd
);
	import lebw_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TMUL = 4'd1;
	localparam logic [3:0] ST_TADD = 4'd2;
	localparam logic [3:0] ST_TSET = 4'd3;
	localparam logic [3:0] ST_CROSS = 4'd4;
	localparam logic [3:0] ST_PREP = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_FIX = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

	logic [3:0]         state_q, state_d;
	logic [DivCntW-1:0] cnt_q;
	logic               m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					if (s_tuser) begin
						state_d = sts.mode ? ST_TMUL : ST_TSET;
					end else begin
						state_d = ST_CROSS;
					end
				end
			end
			ST_TMUL: begin
				cmd.tick_mul = 1'b1;
				state_d = ST_TADD;
			end
			ST_TADD: begin
				cmd.tick_add = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TSET: begin
				cmd.tick_set = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CROSS: begin
				cmd.cross_chk = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = sts.fold ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DivLast) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result register loaded while the previous result is held");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DivLast) |=> (state_q == ST_FIX))
		else $error("division did not end after its last step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted item did not start work");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("result became valid outside the output step");

endmodule

/* rtl/lebw_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, shear shift, crossing logic, radix-4 divider
// for the y fold and the result register. Depends on lebw_pkg.
module lebw_dp #(
	parameter int IMAGE_BITS = lebw_pkg::ImageBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lebw_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [lebw_pkg::CfgW-1:0]     cfg_wdata,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            vel_y,
	input  logic [IMAGE_BITS-1:0]         image_x,
	input  logic [IMAGE_BITS-1:0]         image_y,
	input  lebw_pkg::cmd_t                cmd,
	output lebw_pkg::sts_t                sts,
	output logic signed [31:0]            new_pos_x,
	output logic signed [31:0]            new_pos_y,
	output logic signed [31:0]            new_vel_y,
	output logic [IMAGE_BITS-1:0]         new_image_x,
	output logic [IMAGE_BITS-1:0]         new_image_y
);
	import lebw_pkg::*;

	localparam logic signed [ShiftW-1:0] ShiftMax = {1'b0, {(ShiftW-1){1'b1}}};
	localparam logic signed [ShiftW-1:0] ShiftMin = {1'b1, {(ShiftW-1){1'b0}}};

	// One restoring step: returns the quotient bit above the new remainder.
	function automatic logic [31:0] div_bit(input logic [30:0] rem, input logic din,
		input logic [30:0] dvs);
		logic [31:0] t;
		logic [31:0] diff;
		t = {rem, din};
		diff = t - {1'b0, dvs};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, diff[30:0]};
		end else begin
			return {1'b0, t[30:0]};
		end
	endfunction

	logic               mode_q;
	logic signed [31:0] svel_q, sset_q, lox_q, loy_q;
	logic [31:0]        dt_q;
	logic [30:0]        px_q, py_q;
	logic signed [ShiftW-1:0] shift_q;

	logic signed [31:0]     x_q, y_q, vy_q;
	logic [IMAGE_BITS-1:0]  ix_q, iy_q;

	logic signed [63:0]     prod_q;
	logic signed [64:0]     prod_w;
	logic signed [ShiftW-1:0] inc_w;
	logic signed [ShiftW:0] shift_sum;
	logic signed [ShiftW-1:0] shift_sat;

	logic                   lo_hit, hi_hit;
	logic signed [33:0]     hi_bound;
	logic signed [32:0]     xe, pxe, vye, jmp;
	logic signed [48:0]     ye, se;
	logic signed [32:0]     xw_q, vyw_q;
	logic signed [48:0]     yw_q;
	logic [IMAGE_BITS-1:0]  ixw_q;
	logic                   crossed_q;

	logic signed [49:0]     d_pos, d_neg;
	logic [DivW-1:0]        mag_q;
	logic                   neg_q;
	logic [30:0]            rem_q;
	logic [IMAGE_BITS-1:0]  qd_q;
	logic [31:0]            st1, st2;

	logic signed [32:0]     y_fold;
	logic signed [31:0]     y_res;
	logic [IMAGE_BITS-1:0]  iy_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			svel_q <= '0;
			sset_q <= '0;
			dt_q <= '0;
			lox_q <= '0;
			px_q <= PeriodReset;
			loy_q <= '0;
			py_q <= PeriodReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MODE: mode_q <= cfg_wdata[0];
				CFG_SVEL: svel_q <= cfg_wdata;
				CFG_SSET: sset_q <= cfg_wdata;
				CFG_DT:   dt_q <= cfg_wdata;
				CFG_LOX:  lox_q <= cfg_wdata;
				CFG_PX:   px_q <= cfg_wdata[30:0];
				CFG_LOY:  loy_q <= cfg_wdata;
				CFG_PY:   py_q <= cfg_wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Tick: floor(dt * v / 2^16) is an arithmetic shift of the product.
	assign prod_w = $signed({1'b0, dt_q}) * svel_q;
	assign inc_w = prod_q[63:16];
	assign shift_sum = $signed({shift_q[ShiftW-1], shift_q}) + $signed({inc_w[ShiftW-1], inc_w});
	always_comb begin
		if (shift_sum[ShiftW] != shift_sum[ShiftW-1]) begin
			shift_sat = shift_sum[ShiftW] ? ShiftMin : ShiftMax;
		end else begin
			shift_sat = shift_sum[ShiftW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_mul) begin
			prod_q <= prod_w[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg_we && cfg_idx == CFG_SSET) begin
			shift_q <= {{(ShiftW-32){cfg_wdata[31]}}, cfg_wdata};
		end else if (cmd.tick_set) begin
			shift_q <= {{(ShiftW-32){sset_q[31]}}, sset_q};
		end else if (cmd.tick_add) begin
			shift_q <= shift_sat;
		end
	end

	// Crossing test and single-period correction.
	assign hi_bound = $signed({{2{lox_q[31]}}, lox_q}) + $signed({3'b000, px_q});
	assign lo_hit = x_q < lox_q;
	assign hi_hit = $signed({{2{x_q[31]}}, x_q}) >= hi_bound;
	assign xe = $signed({x_q[31], x_q});
	assign pxe = $signed({2'b00, px_q});
	assign ye = $signed({{17{y_q[31]}}, y_q});
	assign se = $signed({shift_q[ShiftW-1], shift_q});
	assign vye = $signed({vy_q[31], vy_q});
	assign jmp = mode_q ? $signed({svel_q[31], svel_q}) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= pos_x;
			y_q <= pos_y;
			vy_q <= vel_y;
			ix_q <= image_x;
			iy_q <= image_y;
		end
		if (cmd.cross_chk) begin
			if (lo_hit) begin
				xw_q <= xe + pxe;
				yw_q <= ye + se;
				vyw_q <= vye + jmp;
				ixw_q <= ix_q - IMAGE_BITS'(1);
			end else if (hi_hit) begin
				xw_q <= xe - pxe;
				yw_q <= ye - se;
				vyw_q <= vye - jmp;
				ixw_q <= ix_q + IMAGE_BITS'(1);
			end else begin
				xw_q <= xe;
				yw_q <= ye;
				vyw_q <= vye;
				ixw_q <= ix_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crossed_q <= 1'b0;
		end else if (cmd.cross_chk) begin
			crossed_q <= lo_hit || hi_hit;
		end
	end

	assign sts.mode = mode_q;
	assign sts.fold = crossed_q && (py_q != '0);

	// Fold: divide |y - lo_y| by period_y, then turn the truncated result into a floor.
	assign d_pos = $signed({yw_q[48], yw_q}) - $signed({{18{loy_q[31]}}, loy_q});
	assign d_neg = $signed({{18{loy_q[31]}}, loy_q}) - $signed({yw_q[48], yw_q});
	assign st1 = div_bit(rem_q, mag_q[DivW-1], py_q);
	assign st2 = div_bit(st1[30:0], mag_q[DivW-2], py_q);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q <= d_pos[49];
			mag_q <= d_pos[49] ? d_neg : d_pos;
			rem_q <= '0;
			qd_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[DivW-3:0], 2'b00};
			rem_q <= st2[30:0];
			qd_q <= {qd_q[IMAGE_BITS-3:0], st1[31], st2[31]};
		end else if (cmd.fix) begin
			if (neg_q) begin
				if (rem_q == '0) begin
					qd_q <= ~qd_q + IMAGE_BITS'(1);
				end else begin
					qd_q <= ~qd_q;
					rem_q <= py_q - rem_q;
				end
			end
		end
	end

	assign y_fold = $signed({2'b00, rem_q}) + $signed({loy_q[31], loy_q});
	assign y_res = sts.fold ? sat32({{17{y_fold[32]}}, y_fold}) : sat32({yw_q[48], yw_q});
	assign iy_res = sts.fold ? iy_q + qd_q : iy_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			new_pos_x <= sat32({{17{xw_q[32]}}, xw_q});
			new_pos_y <= y_res;
			new_vel_y <= sat32({{17{vyw_q[32]}}, vyw_q});
			new_image_x <= ixw_q;
			new_image_y <= iy_res;
		end
	end

endmodule

/* rtl/lees_edwards_boundary_wrap.sv */
`timescale 1ns / 1ps
// Sheared periodic boundary (sliding-brick) for one particle per transfer.
// Depends on lebw_pkg, lebw_ctrl and lebw_dp.
//
// Input stream: tuser selects the item kind (0 wraps a particle, 1 updates the
// shear shift). A wrap item gives one result on the output stream; a tick item
// gives none. The user must write configuration through cfg_we/cfg_idx/cfg_wdata
// only while the block is idle; the block does not enforce this. Writing
// shift_setting also reloads the shear shift.
// Sequence: one item is worked on at a time. A wrap item passes the crossing
// check and the preparation; if it crossed a face in x and the y period is not
// zero, the radix-4 divider folds y into the box and the floor fix follows, then
// the output step. A tick item runs the multiply and add steps (mode 1) or the
// set step (mode 0). s_axis_tready is high again in the cycle after the result
// is loaded into the output register.
//
// The output register holds a result until it is taken; if the receiver stalls,
// the block finishes the next item and then waits with s_axis_tready low.
// Reset clears the shift, restores the register defaults (both periods 1.0)
// and empties the output register.
module lees_edwards_boundary_wrap #(
	parameter int IMAGE_BITS = lebw_pkg::ImageBitsDefault
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// pos_x, pos_y, vel_y, image_x, image_y, zero fill
	input  logic [((96 + 2 * IMAGE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// func
	input  logic                                    s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// new_pos_x, new_pos_y, new_vel_y, new_image_x, new_image_y, zero fill
	output logic [((96 + 2 * IMAGE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                                    cfg_we,
	input  logic [lebw_pkg::CfgIdxW-1:0]            cfg_idx,
	input  logic [lebw_pkg::CfgW-1:0]               cfg_wdata
);
	import lebw_pkg::*;

	localparam int FieldW = 96 + 2 * IMAGE_BITS;
	localparam int IxLo = 96;
	localparam int IyLo = 96 + IMAGE_BITS;

	cmd_t cmd;
	sts_t sts;

	logic signed [31:0]    o_pos_x, o_pos_y, o_vel_y;
	logic [IMAGE_BITS-1:0] o_image_x, o_image_y;

	lebw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tuser  (s_axis_tuser),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lebw_dp #(
		.IMAGE_BITS (IMAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.pos_x       (s_axis_tdata[31:0]),
		.pos_y       (s_axis_tdata[63:32]),
		.vel_y       (s_axis_tdata[95:64]),
		.image_x     (s_axis_tdata[IxLo +: IMAGE_BITS]),
		.image_y     (s_axis_tdata[IyLo +: IMAGE_BITS]),
		.cmd         (cmd),
		.sts         (sts),
		.new_pos_x   (o_pos_x),
		.new_pos_y   (o_pos_y),
		.new_vel_y   (o_vel_y),
		.new_image_x (o_image_x),
		.new_image_y (o_image_y)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[FieldW-1:0] = {o_image_y, o_image_x, o_vel_y, o_pos_y, o_pos_x};
	end

endmodule
